### hdl/rop_pkg.sv
// shared types and constants of the radius outlier point filter
package rop_pkg;

   localparam int COORD_W            = 15;
   localparam int RADIUS_W           = 12;
   localparam int POS_W              = 6;
   localparam int DIFF_W             = COORD_W + 1;
   localparam int PROD_W             = 2 * DIFF_W;
   localparam int SQ_W               = 2 * COORD_W;
   localparam int SUM_W              = SQ_W + 1;
   localparam int R2_W               = 2 * RADIUS_W;
   localparam int REQ_DATA_W         = 32;
   localparam int RSP_DATA_W         = 40;
   localparam int RSP_USER_W         = 2;
   localparam int USER_NONE_KEPT     = 0;
   localparam int USER_OVERFLOW      = 1;
   localparam int MAX_POINTS_DEFAULT = 64;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 12'd200;

   // point travelling down the row, with the squares against the previous cell
   typedef struct packed {
      logic                      valid;
      logic                      cmp;
      logic                      last;
      logic                      flag;
      logic                      sqv;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [SQ_W-1:0]           sqx;
      logic [SQ_W-1:0]           sqy;
   } token_type;

   // point held by one cell
   typedef struct packed {
      logic                      valid;
      logic                      flag;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } slot_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } chain_ctrl_type;

   typedef struct packed {
      logic     any_kept;
      logic     more_kept;
      logic     exit_last;
      slot_type head;
   } chain_status_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_DRAIN,
      ST_EMIT
   } state_type;

endpackage

### hdl/rop_cell.sv
// one cell of the point row: holds a point and tests passing points against it
module rop_cell
   import rop_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic [R2_W-1:0] r2,
   input  chain_ctrl_type  ctrl,
   input  token_type       token_i,
   output token_type       token_o,
   input  logic            hit_next_i,
   output logic            hit_prev_o,
   input  slot_type        slot_next_i,
   output slot_type        slot_o
);

   token_type                token_ff, token_in;
   slot_type                 slot_ff, slot_in;
   logic signed [DIFF_W-1:0] dx, dy;
   logic signed [PROD_W-1:0] prod_x, prod_y;
   logic [SUM_W-1:0]         sum;
   logic                     hit;

   always_comb begin
      // squares handed on by the previous cell decide its neighbour test here
      sum = {1'b0, token_i.sqx} + {1'b0, token_i.sqy};
      hit = token_i.valid && token_i.sqv && (sum <= SUM_W'(r2));
      hit_prev_o = hit;

      dx = {token_i.x[COORD_W-1], token_i.x} - {slot_ff.x[COORD_W-1], slot_ff.x};
      dy = {token_i.y[COORD_W-1], token_i.y} - {slot_ff.y[COORD_W-1], slot_ff.y};
      prod_x = dx * dx;
      prod_y = dy * dy;

      token_in      = token_i;
      token_in.flag = token_i.flag | hit;
      token_in.sqv  = 1'b0;
      token_in.sqx  = prod_x[SQ_W-1:0];
      token_in.sqy  = prod_y[SQ_W-1:0];

      slot_in      = slot_ff;
      slot_in.flag = slot_ff.flag | hit_next_i;

      if (ctrl.clear) begin
         slot_in.valid = 1'b0;
         slot_in.flag  = 1'b0;
      end else if (ctrl.shift) begin
         slot_in = slot_next_i;
      end else if (token_i.valid && token_i.cmp) begin
         if (slot_ff.valid) begin
            token_in.sqv = 1'b1;
         end else begin
            // first free cell: the point settles here
            slot_in.valid = 1'b1;
            slot_in.flag  = token_i.flag | hit;
            slot_in.x     = token_i.x;
            slot_in.y     = token_i.y;
            token_in.cmp  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff.valid <= 1'b0;
         slot_ff.valid  <= 1'b0;
         slot_ff.flag   <= 1'b0;
      end else begin
         token_ff <= token_in;
         slot_ff  <= slot_in;
      end
   end

   assign token_o = token_ff;
   assign slot_o  = slot_ff;

endmodule

### hdl/rop_chain.sv
// row of point cells with the summary flags the sequencer needs
module rop_chain
   import rop_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [R2_W-1:0]  r2,
   input  chain_ctrl_type   ctrl,
   input  token_type        in_token,
   output chain_status_type status
);

   token_type             token_q [MAX_POINTS];
   slot_type              slot_q  [MAX_POINTS];
   logic                  hit_q   [MAX_POINTS];
   logic [MAX_POINTS-1:0] flags;

   for (genvar j = 0; j < MAX_POINTS; j++) begin : g_cell
      token_type tok_i;
      logic      hit_n;
      slot_type  slot_n;

      if (j == 0) begin : g_first
         assign tok_i = in_token;
      end else begin : g_mid
         assign tok_i = token_q[j-1];
      end

      if (j == MAX_POINTS - 1) begin : g_end
         assign hit_n  = 1'b0;
         assign slot_n = '0;
      end else begin : g_link
         assign hit_n  = hit_q[j+1];
         assign slot_n = slot_q[j+1];
      end

      rop_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .r2          (r2),
         .ctrl        (ctrl),
         .token_i     (tok_i),
         .token_o     (token_q[j]),
         .hit_next_i  (hit_n),
         .hit_prev_o  (hit_q[j]),
         .slot_next_i (slot_n),
         .slot_o      (slot_q[j])
      );

      assign flags[j] = slot_q[j].flag;
   end

   assign status.any_kept  = |flags;
   assign status.more_kept = |flags[MAX_POINTS-1:1];
   assign status.exit_last = token_q[MAX_POINTS-1].valid && token_q[MAX_POINTS-1].last;
   assign status.head      = slot_q[0];

endmodule

### hdl/radius_outlier_point_filter.sv
// top level of the radius outlier point filter: handshakes, sequencer and output register
//
// usage
//  - req_ carries one scan of 2d points, one point per transaction; req_tlast marks
//    the final point of the scan
//  - rsp_ returns every point that has another point within the radius, in input
//    order with its index; rsp_tlast marks the final result of the scan, and a scan
//    with no such point gives one result with the none-kept flag in rsp_tuser
//  - csr_we / csr_wdata set the radius in mm; write only while no scan is open
// timing
//  - while loading, one point per cycle is taken: each point runs down the row of
//    cells one cell a cycle, tested against the point held there on its way
//  - after the final point the row drains until the scan end leaves the last
//    cell, then the stored points are shifted out of cell 0 at one cell a cycle;
//    a kept point shifts on only once the output register is free to take it
//  - req_tready is low from the last point until the final result is registered
// reset clears the row, the point count and the overflow flag; the radius
// returns to 200 mm
// a stalled receiver holds the output register and the shift-out waits with it
module radius_outlier_point_filter
   import rop_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   // config: radius in mm
   input  logic                  csr_we,
   input  logic [RADIUS_W-1:0]   csr_wdata,
   // tdata: x_mm [14:0], y_mm [29:15], zero padding [31:30]
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   // tdata: kept_x [14:0], kept_y [29:15], position [35:30], zero padding [39:36]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // tuser: none_kept [0], overflow [1]
   output logic [RSP_USER_W-1:0] rsp_tuser,
   output logic                  rsp_tlast
);

   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam logic [R2_W-1:0] R2_RESET = R2_W'(RADIUS_RESET) * R2_W'(RADIUS_RESET);

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      ovf_ff, ovf_in;
   logic [POS_W-1:0]          pos_ff, pos_in;
   logic [RADIUS_W-1:0]       radius_ff;
   logic [R2_W-1:0]           r2_ff;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_W-1:0] rsp_x_ff, rsp_x_in;
   logic signed [COORD_W-1:0] rsp_y_ff, rsp_y_in;
   logic [POS_W-1:0]          rsp_pos_ff, rsp_pos_in;
   logic                      rsp_none_ff, rsp_none_in;
   logic                      rsp_ovf_ff, rsp_ovf_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic                      accept, full, out_free, load_out;
   token_type                 in_token;
   chain_ctrl_type            ctrl;
   chain_status_type          status;

   assign accept   = req_tvalid && req_tready;
   assign full     = (count_ff == CNT_W'(MAX_POINTS));
   assign out_free = !rsp_valid_ff || rsp_tready;

   // incoming point enters cell 0; once the row is full it only carries the scan end
   always_comb begin
      in_token       = '0;
      in_token.valid = accept;
      in_token.cmp   = !full;
      in_token.last  = req_tlast;
      in_token.x     = req_tdata[COORD_W-1:0];
      in_token.y     = req_tdata[2*COORD_W-1:COORD_W];
   end

   rop_chain #(
      .MAX_POINTS (MAX_POINTS)
   ) u_chain (
      .clock    (clock),
      .reset    (reset),
      .r2       (r2_ff),
      .ctrl     (ctrl),
      .in_token (in_token),
      .status   (status)
   );

   // sequencer: load, wait for the row to settle, then shift the points out
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      pos_in      = pos_ff;
      ctrl        = '0;
      req_tready  = (state_ff == ST_LOAD);
      load_out    = 1'b0;
      rsp_x_in    = rsp_x_ff;
      rsp_y_in    = rsp_y_ff;
      rsp_pos_in  = rsp_pos_ff;
      rsp_none_in = rsp_none_ff;
      rsp_ovf_in  = rsp_ovf_ff;
      rsp_last_in = rsp_last_ff;

      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  count_in = count_ff + 1'b1;
               end
               if (req_tlast) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (status.exit_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!status.any_kept) begin
               // nothing survived: one empty result closes the scan
               if (out_free) begin
                  load_out    = 1'b1;
                  rsp_x_in    = '0;
                  rsp_y_in    = '0;
                  rsp_pos_in  = '0;
                  rsp_none_in = 1'b1;
                  rsp_ovf_in  = ovf_ff;
                  rsp_last_in = 1'b1;
                  ctrl.clear  = 1'b1;
                  state_in    = ST_LOAD;
                  count_in    = '0;
                  ovf_in      = 1'b0;
                  pos_in      = '0;
               end
            end else if (!status.head.flag) begin
               // point without a neighbour at the head: skip it
               ctrl.shift = 1'b1;
               pos_in     = pos_ff + 1'b1;
            end else if (out_free) begin
               load_out    = 1'b1;
               rsp_x_in    = status.head.x;
               rsp_y_in    = status.head.y;
               rsp_pos_in  = pos_ff;
               rsp_none_in = 1'b0;
               rsp_ovf_in  = ovf_ff;
               rsp_last_in = !status.more_kept;
               if (status.more_kept) begin
                  ctrl.shift = 1'b1;
                  pos_in     = pos_ff + 1'b1;
               end else begin
                  ctrl.clear = 1'b1;
                  state_in   = ST_LOAD;
                  count_in   = '0;
                  ovf_in     = 1'b0;
                  pos_in     = '0;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase

      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         radius_ff    <= RADIUS_RESET;
         r2_ff        <= R2_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            radius_ff <= csr_wdata;
         end
         // squared radius follows the register in the next cycle
         r2_ff <= R2_W'(radius_ff) * R2_W'(radius_ff);
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_none_ff <= rsp_none_in;
      rsp_ovf_ff  <= rsp_ovf_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - 2*COORD_W - POS_W)'(0), rsp_pos_ff, rsp_y_ff, rsp_x_ff};
   assign rsp_tuser  = {rsp_ovf_ff, rsp_none_ff};
   assign rsp_tlast  = rsp_last_ff;

   // the scan end leaves the row only while the sequencer waits for it
   a_exit_in_drain : assert property (@(posedge clock) disable iff (reset)
      status.exit_last |-> state_ff == ST_DRAIN)
      else $error("scan end left the row outside the drain phase");

   // no new point is taken once a scan has been closed
   a_no_take_after_last : assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast) |=> !req_tready)
      else $error("point taken after the scan end");

   // an empty result is always the final result of its scan
   a_none_is_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[USER_NONE_KEPT]) |-> rsp_tlast)
      else $error("empty result not marked last");

   // the point count never passes the row length
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_POINTS))
      else $error("point count beyond capacity");

endmodule

### tb/tb_top.sv
// self-checking testbench of the radius outlier point filter
module tb_top;
   import rop_pkg::*;

   localparam int CAPACITY   = MAX_POINTS_DEFAULT;
   // quiet cycles left before a radius write and before the end of the run
   localparam int DRAIN_GAP  = CAPACITY + 8;
   localparam int IDLE_PCT   = 12;
   localparam int MIN_POINTS = 240;
   localparam int MAX_SHOWN  = 40;

   typedef struct {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [POS_W-1:0]          pos;
      logic                      none_kept;
      logic                      overflow;
      logic                      last;
   } kept_point_type;

   // one directed point; set_r writes the radius before it, lit means the scan's
   // single result is the plain nothing-kept result
   typedef struct packed {
      logic                      set_r;
      logic [RADIUS_W-1:0]       radius;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic                      last;
      logic                      lit;
   } plan_row_type;

   localparam int N_PLAN = 15;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_we     = 1'b0;
   logic [RADIUS_W-1:0]   csr_wdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  rsp_tlast;

   logic no_gaps = 1'b0;

   // predictor state: the points of the open scan and their neighbour flags
   logic signed [COORD_W-1:0] scan_x [CAPACITY];
   logic signed [COORD_W-1:0] scan_y [CAPACITY];
   logic                      has_neighbour [CAPACITY];
   int                        n_stored     = 0;
   logic                      dropped_any  = 1'b0;
   logic [RADIUS_W-1:0]       radius_now   = RADIUS_RESET;

   kept_point_type expected_kept [$];

   int error_count    = 0;
   int points_sent    = 0;
   int scans_done     = 0;
   int results_seen   = 0;
   int overflow_scans = 0;
   int radius_writes  = 0;

   plan_row_type plan [N_PLAN] = '{
      // single point under the reset radius: nothing kept
      '{0, 0, 0, 0, 1, 1},
      // exactly on the reset radius, then a point just outside it
      '{0, 0, 0, 0, 0, 0},
      '{0, 0, 200, 0, 0, 0},
      '{0, 0, -141, -142, 1, 0},
      // widest radius, opposite corners: nothing kept
      '{1, 4095, -16384, -16384, 0, 0},
      '{0, 0, 16383, 16383, 1, 1},
      // widest radius, neighbour at exactly the radius along y
      '{0, 0, -16384, 16383, 0, 0},
      '{0, 0, -16384, 12288, 0, 0},
      '{0, 0, 16383, -16384, 1, 0},
      // zero radius: only coincident points count
      '{1, 0, 5, -5, 0, 0},
      '{0, 0, 6, -5, 0, 0},
      '{0, 0, 5, -5, 1, 0},
      '{0, 0, 16383, -16384, 0, 0},
      '{0, 0, 16383, -16384, 1, 0},
      // zero radius, lone point
      '{0, 0, -1, -1, 1, 1}
   };

   radius_outlier_point_filter #(
      .MAX_POINTS (CAPACITY)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver stalls at random outside the calm stretch
   always @(posedge clock) begin
      rsp_tready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      if (error_count < MAX_SHOWN)
         $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      error_count++;
   endtask

   // neighbour test and, on the final point, the list of kept points
   task automatic predict_kept_points(input logic signed [COORD_W-1:0] x,
                                      input logic signed [COORD_W-1:0] y,
                                      input logic last);
      longint         dx;
      longint         dy;
      longint         r2;
      int             n_kept;
      kept_point_type res;
      r2 = longint'(radius_now) * longint'(radius_now);
      if (n_stored < CAPACITY) begin
         for (int i = 0; i < n_stored; i++) begin
            dx = longint'(x) - longint'(scan_x[i]);
            dy = longint'(y) - longint'(scan_y[i]);
            if (dx * dx + dy * dy <= r2) begin
               has_neighbour[i]        = 1'b1;
               has_neighbour[n_stored] = 1'b1;
            end
         end
         scan_x[n_stored] = x;
         scan_y[n_stored] = y;
         n_stored++;
      end else begin
         dropped_any = 1'b1;
      end
      if (last) begin
         n_kept = 0;
         for (int i = 0; i < n_stored; i++) begin
            if (has_neighbour[i]) begin
               res.x         = scan_x[i];
               res.y         = scan_y[i];
               res.pos       = POS_W'(i);
               res.none_kept = 1'b0;
               res.overflow  = dropped_any;
               res.last      = 1'b0;
               expected_kept.insert(expected_kept.size(), res);
               n_kept++;
            end
         end
         if (n_kept == 0) begin
            res.x         = '0;
            res.y         = '0;
            res.pos       = '0;
            res.none_kept = 1'b1;
            res.overflow  = dropped_any;
            res.last      = 1'b1;
            expected_kept.insert(expected_kept.size(), res);
         end else begin
            expected_kept[expected_kept.size() - 1].last = 1'b1;
         end
         if (dropped_any)
            overflow_scans++;
         scans_done++;
         for (int i = 0; i < CAPACITY; i++)
            has_neighbour[i] = 1'b0;
         n_stored    = 0;
         dropped_any = 1'b0;
      end
   endtask

   // radius changes only once the previous scan has fully drained
   task automatic program_radius(input logic [RADIUS_W-1:0] value);
      req_tvalid <= 1'b0;
      while (expected_kept.size() != 0)
         @(posedge clock);
      repeat (DRAIN_GAP) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we     <= 1'b0;
      radius_now = value;
      radius_writes++;
   endtask

   task automatic send_point(input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y,
                             input logic last);
      if (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         do
            @(posedge clock);
         while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, y, x};
      req_tlast  <= last;
      do
         @(posedge clock);
      while (!req_tready);
      predict_kept_points(x, y, last);
      points_sent++;
   endtask

   // every result transaction against the oldest expectation
   always @(posedge clock) begin : check_results
      kept_point_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_kept.size() == 0) begin
            report_mismatch("result with none pending, position",
                            int'(rsp_tdata[35:30]), -1);
         end else begin
            want = expected_kept.pop_front();
            results_seen++;
            if ($signed(rsp_tdata[14:0]) !== want.x)
               report_mismatch("kept_x", int'($signed(rsp_tdata[14:0])), int'(want.x));
            if ($signed(rsp_tdata[29:15]) !== want.y)
               report_mismatch("kept_y", int'($signed(rsp_tdata[29:15])), int'(want.y));
            if (rsp_tdata[35:30] !== want.pos)
               report_mismatch("position", int'(rsp_tdata[35:30]), int'(want.pos));
            if (rsp_tuser[USER_NONE_KEPT] !== want.none_kept)
               report_mismatch("none_kept", int'(rsp_tuser[USER_NONE_KEPT]),
                               int'(want.none_kept));
            if (rsp_tuser[USER_OVERFLOW] !== want.overflow)
               report_mismatch("overflow", int'(rsp_tuser[USER_OVERFLOW]),
                               int'(want.overflow));
            if (rsp_tlast !== want.last)
               report_mismatch("tlast", int'(rsp_tlast), int'(want.last));
         end
      end
   end

   initial begin
      int                        scan_no;
      int                        n;
      int                        cx;
      int                        cy;
      int                        spread;
      logic signed [COORD_W-1:0] px;
      logic signed [COORD_W-1:0] py;
      logic [RADIUS_W-1:0]       r;
      kept_point_type            lit_res;

      for (int i = 0; i < CAPACITY; i++)
         has_neighbour[i] = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < N_PLAN; i++) begin
         if (plan[i].set_r)
            program_radius(plan[i].radius);
         send_point(plan[i].x, plan[i].y, plan[i].last);
         if (plan[i].lit) begin
            // replace the prediction with the typed-in nothing-kept result
            void'(expected_kept.pop_back());
            lit_res.x         = '0;
            lit_res.y         = '0;
            lit_res.pos       = '0;
            lit_res.none_kept = 1'b1;
            lit_res.overflow  = 1'b0;
            lit_res.last      = 1'b1;
            expected_kept.insert(expected_kept.size(), lit_res);
         end
      end

      // random scans: clustered points with some noise, two scans past capacity
      scan_no = 0;
      while (points_sent < MIN_POINTS) begin
         no_gaps <= (scan_no >= 6 && scan_no < 10);
         if (scan_no == 1) begin
            program_radius(RADIUS_W'($urandom_range(100, 600)));
            n = CAPACITY + $urandom_range(1, 3);
         end else if (scan_no == 4) begin
            // zero radius over the full range: nothing kept, overflow still flagged
            program_radius('0);
            n = CAPACITY + 2;
         end else begin
            if ($urandom_range(0, 2) == 0) begin
               case ($urandom_range(0, 3))
                  0:       r = '0;
                  1:       r = '1;
                  default: r = RADIUS_W'($urandom_range(1, 4094));
               endcase
               program_radius(r);
            end
            n = $urandom_range(1, 12);
         end
         cx = int'($urandom_range(0, 32767)) - 16384;
         cy = int'($urandom_range(0, 32767)) - 16384;
         spread = int'(radius_now) + int'(radius_now) / 4 + 1;
         for (int p = 0; p < n; p++) begin
            if (scan_no == 4 || $urandom_range(0, 3) == 0) begin
               px = COORD_W'($urandom);
               py = COORD_W'($urandom);
            end else begin
               px = COORD_W'(cx + int'($urandom_range(0, 2 * spread)) - spread);
               py = COORD_W'(cy + int'($urandom_range(0, 2 * spread)) - spread);
            end
            send_point(px, py, p == n - 1);
         end
         scan_no++;
      end

      req_tvalid <= 1'b0;
      no_gaps    <= 1'b0;
      while (expected_kept.size() != 0)
         @(posedge clock);
      repeat (DRAIN_GAP) @(posedge clock);

      $display("covered %0d points in %0d scans, %0d of them past capacity",
               points_sent, scans_done, overflow_scans);
      $display("checked %0d results over %0d radius settings", results_seen,
               radius_writes + 1);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #2000000;
      $display("run timed out");
      $display("DONE: errors detected");
      $finish;
   end

endmodule
